// ----- rtl/core/rolling_hash_pattern_matcher_defines.svh -----
// Assertion macros shared by the matcher RTL.
`ifndef ROLLING_HASH_PATTERN_MATCHER_DEFINES_SVH
`define ROLLING_HASH_PATTERN_MATCHER_DEFINES_SVH

// A property checked at every clock edge outside reset.
`define RHPM_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("rhpm: check failed");

// A property that must also hold while reset is applied.
`define RHPM_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("rhpm: check failed");

`endif

// ----- rtl/core/rhpm_pkg.sv -----
`default_nettype none

package rhpm_pkg;

  // Defaults of the top level parameters.
  localparam int unsigned MaxPatternDef = 64;
  localparam int unsigned PosBitsDef    = 32;

  // Register file of the configuration port.
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] REG_HASH_BASE = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_HASH_MOD  = 2'd1;
  localparam logic [30:0] HASH_BASE_RST = 31'd257;
  localparam logic [30:0] HASH_MOD_RST  = 31'd1000000007;

  // Operations of the shared modular unit.
  typedef enum logic {
    MM_REDUCE,
    MM_MUL
  } mm_op_e;

  typedef struct packed {
    logic        start;
    mm_op_e      op;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] m;
  } mm_cmd_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [31:0] result;
  } mm_rsp_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_BRED,
    ST_P_BP,
    ST_P_PH,
    ST_P_ADD,
    ST_T_HRED,
    ST_T_BPRED,
    ST_T_SUB,
    ST_T_FIX,
    ST_T_MUL,
    ST_T_ADD,
    ST_T_PHRED,
    ST_T_CHK,
    ST_V_RD,
    ST_V_CMP,
    ST_FIN
  } state_e;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    sat_inc = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/rhpm_if.sv -----
`default_nettype none

// Input word channel.
interface rhpm_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, func, data_byte, last_byte, input ready);
  modport sink   (input valid, func, data_byte, last_byte, output ready);
endinterface

// Result word channel.
interface rhpm_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] match_position;
  logic        verified;
  logic [31:0] matches_in_search;
  logic [31:0] collision_total;
  logic [31:0] search_total;
  modport source (output valid, match_position, verified, matches_in_search,
                  collision_total, search_total, input ready);
  modport sink   (input valid, match_position, verified, matches_in_search,
                  collision_total, search_total, output ready);
endinterface

// Configuration write channel.
interface rhpm_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [rhpm_pkg::CfgIdxW-1:0] index;
  logic [31:0]                 wdata;
  modport source (output valid, index, wdata, input ready);
  modport sink   (input valid, index, wdata, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/rhpm_modmul.sv -----
`default_nettype none

// Bit-serial modular unit. It walks x from the top bit, one bit a cycle:
// r = (2r + a) mod m, with a = bit for a reduction and a = bit ? y : 0 for
// a product. y must already be below m.
module rhpm_modmul (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire rhpm_pkg::mm_cmd_t cmd_i,
  output rhpm_pkg::mm_rsp_t     rsp_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [4:0]           cnt_q, cnt_d;
  logic [31:0]          r_q, r_d;
  logic [31:0]          x_q, x_d;
  logic [31:0]          y_q, y_d;
  logic [31:0]          m_q, m_d;
  rhpm_pkg::mm_op_e     op_q, op_d;
  logic [32:0]          dbl, dbl_red, sum;
  logic [31:0]          addend;

  // One step: double and reduce, then add and reduce.
  always_comb begin
    dbl     = {r_q, 1'b0};
    dbl_red = (dbl >= {1'b0, m_q}) ? dbl - {1'b0, m_q} : dbl;
    if (op_q == rhpm_pkg::MM_REDUCE) begin
      addend = {31'd0, x_q[31]};
    end else begin
      addend = x_q[31] ? y_q : 32'd0;
    end
    sum = dbl_red + {1'b0, addend};
    if (sum >= {1'b0, m_q}) begin
      sum = sum - {1'b0, m_q};
    end
  end

  // Sequencing of the 32 steps.
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    r_d    = r_q;
    x_d    = x_q;
    y_d    = y_q;
    m_d    = m_q;
    op_d   = op_q;
    if (busy_q) begin
      r_d   = sum[31:0];
      x_d   = {x_q[30:0], 1'b0};
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (cmd_i.start) begin
      busy_d = 1'b1;
      cnt_d  = 5'd0;
      r_d    = 32'd0;
      x_d    = cmd_i.x;
      y_d    = cmd_i.y;
      m_d    = cmd_i.m;
      op_d   = cmd_i.op;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 5'd0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q  <= r_d;
    x_q  <= x_d;
    y_q  <= y_d;
    m_q  <= m_d;
    op_q <= op_d;
  end

  assign rsp_o.busy   = busy_q;
  assign rsp_o.done   = done_q;
  assign rsp_o.result = r_q;

endmodule

`default_nettype wire

// ----- rtl/core/rolling_hash_pattern_matcher.sv -----
// Channel | Dir | Word
// in_if   | in  | func, data_byte, last_byte
// out_if  | out | match_position, verified, matches_in_search, collision_total,
//         |     | search_total
// cfg_if  | in  | index, wdata (hash_base, hash_modulus)
//
// Every operation of the modular unit is a start, 32 bit steps and a done. A first
// pattern byte reduces the base, multiplies and adds; a later kept one also raises
// the power; a text byte reduces base and window hash, drops the oldest byte once
// the window is full, multiplies, adds, reduces pattern hash and verifies a hit.
// Bytes that change no hash (dropped pattern bytes, text with no pattern) start no
// unit operation. Reset is asynchronous and active low; the memories need no
// clearing. A finished word waits in the output register while the next byte is
// taken; a text byte waits in its final stage while that register is still full.
// Configuration is written only while the block is idle and no byte is offered.
`default_nettype none

`include "rolling_hash_pattern_matcher_defines.svh"

module rolling_hash_pattern_matcher #(
  parameter int unsigned MAX_PATTERN   = rhpm_pkg::MaxPatternDef,
  parameter int unsigned POSITION_BITS = rhpm_pkg::PosBitsDef
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  rhpm_in_if.sink     in_if,
  rhpm_out_if.source  out_if,
  rhpm_cfg_if.sink    cfg_if
);

  localparam int unsigned IdxW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int unsigned LenW = $clog2(MAX_PATTERN + 1);
  localparam int unsigned PosW = POSITION_BITS;
  localparam int unsigned ExtW = (PosW > 32) ? PosW : 32;
  localparam logic [LenW-1:0] MaxLen = LenW'(MAX_PATTERN);

  rhpm_pkg::state_e state_q, state_d;

  // Configuration registers.
  logic [30:0] base_q, mod_q;
  logic [31:0] m_eff;

  // Search state.
  logic [LenW-1:0] len_q, fill_q;
  logic            complete_q;
  logic [30:0]     ph_q, bp_q, wh_q;
  logic [PosW-1:0] pos_q;
  logic [IdxW-1:0] ptr_q;
  logic [31:0]     mc_q, cc_q, sc_q;

  // Working registers.
  logic [30:0]     b_q, acc_q, bpr_q, sub_q, phr_q;
  logic [7:0]      byte_q;
  logic            last_q, txt_q, first_q, iss_q, ok_q, hit_q;
  logic [IdxW-1:0] q_q;
  logic [IdxW-1:0] k_q;

  // Memories.
  logic [7:0]      pstore [MAX_PATTERN];
  logic [7:0]      ring   [MAX_PATTERN];
  logic [7:0]      ring_rd_q, pat_rd_q;
  logic [IdxW-1:0] ring_raddr;

  // Output register.
  logic        ov_q;
  logic [31:0] o_pos_q, o_mc_q, o_cc_q, o_sc_q;
  logic        o_ver_q;

  rhpm_pkg::mm_cmd_t mm_cmd;
  rhpm_pkg::mm_rsp_t mm_rsp;

  logic            in_acc, op_state, fin_go, out_load;
  logic [LenW-1:0] len_eff, fill_inc;
  logic [32:0]     fix_sum;
  logic [IdxW-1:0] ptr_nx, q_nx;
  logic [31:0]     mc_n, cc_n, sc_n;
  logic [PosW-1:0] start_pos;
  logic [ExtW-1:0] start_ext;

  rhpm_modmul u_modmul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (mm_cmd),
    .rsp_o  (mm_rsp)
  );

  assign m_eff    = (mod_q == 31'd0) ? 32'h8000_0000 : {1'b0, mod_q};
  assign in_acc   = in_if.valid && in_if.ready;
  assign len_eff  = complete_q ? '0 : len_q;
  assign fill_inc = (fill_q < len_q) ? fill_q + 1'b1 : fill_q;
  assign fix_sum  = {2'b0, acc_q} + {1'b0, m_eff} - {2'b0, sub_q};
  assign ptr_nx   = (LenW'(ptr_q) + 1'b1 == len_q) ? '0 : ptr_q + 1'b1;
  assign q_nx     = (LenW'(q_q) + 1'b1 == len_q) ? '0 : q_q + 1'b1;
  assign fin_go   = !ov_q || out_if.ready;
  assign out_load = (state_q == rhpm_pkg::ST_FIN) && fin_go && hit_q;

  // Counters after this text byte.
  assign mc_n = (hit_q && ok_q) ? rhpm_pkg::sat_inc(mc_q) : mc_q;
  assign cc_n = (hit_q && !ok_q) ? rhpm_pkg::sat_inc(cc_q) : cc_q;
  assign sc_n = (last_q && fill_q >= len_q) ? rhpm_pkg::sat_inc(sc_q) : sc_q;
  assign start_pos = pos_q - PosW'(len_q - 1'b1);
  assign start_ext = ExtW'(start_pos);

  // Configuration writes are taken only while no byte is being worked on.
  assign cfg_if.ready = (state_q == rhpm_pkg::ST_IDLE) && !in_if.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= rhpm_pkg::HASH_BASE_RST;
      mod_q  <= rhpm_pkg::HASH_MOD_RST;
    end else if (cfg_if.valid && cfg_if.ready) begin
      unique case (cfg_if.index)
        rhpm_pkg::REG_HASH_BASE: base_q <= cfg_if.wdata[30:0];
        rhpm_pkg::REG_HASH_MOD:  mod_q  <= cfg_if.wdata[30:0];
        default: ;
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rhpm_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (!in_if.func && len_eff < MaxLen) begin
            state_d = rhpm_pkg::ST_BRED;
          end else if (in_if.func && len_q != '0) begin
            state_d = rhpm_pkg::ST_BRED;
          end
        end
      end
      rhpm_pkg::ST_BRED: begin
        if (mm_rsp.done) begin
          if (txt_q) begin
            state_d = rhpm_pkg::ST_T_HRED;
          end else if (first_q) begin
            state_d = rhpm_pkg::ST_P_PH;
          end else begin
            state_d = rhpm_pkg::ST_P_BP;
          end
        end
      end
      rhpm_pkg::ST_P_BP:  if (mm_rsp.done) state_d = rhpm_pkg::ST_P_PH;
      rhpm_pkg::ST_P_PH:  if (mm_rsp.done) state_d = rhpm_pkg::ST_P_ADD;
      rhpm_pkg::ST_P_ADD: if (mm_rsp.done) state_d = rhpm_pkg::ST_IDLE;
      rhpm_pkg::ST_T_HRED: begin
        if (mm_rsp.done) begin
          state_d = (fill_q >= len_q) ? rhpm_pkg::ST_T_BPRED : rhpm_pkg::ST_T_MUL;
        end
      end
      rhpm_pkg::ST_T_BPRED: if (mm_rsp.done) state_d = rhpm_pkg::ST_T_SUB;
      rhpm_pkg::ST_T_SUB:   if (mm_rsp.done) state_d = rhpm_pkg::ST_T_FIX;
      rhpm_pkg::ST_T_FIX:   state_d = rhpm_pkg::ST_T_MUL;
      rhpm_pkg::ST_T_MUL:   if (mm_rsp.done) state_d = rhpm_pkg::ST_T_ADD;
      rhpm_pkg::ST_T_ADD:   if (mm_rsp.done) state_d = rhpm_pkg::ST_T_PHRED;
      rhpm_pkg::ST_T_PHRED: if (mm_rsp.done) state_d = rhpm_pkg::ST_T_CHK;
      rhpm_pkg::ST_T_CHK: begin
        if (fill_q >= len_q && wh_q == phr_q) begin
          state_d = rhpm_pkg::ST_V_RD;
        end else begin
          state_d = rhpm_pkg::ST_FIN;
        end
      end
      rhpm_pkg::ST_V_RD: state_d = rhpm_pkg::ST_V_CMP;
      rhpm_pkg::ST_V_CMP: begin
        if (ring_rd_q != pat_rd_q || LenW'(k_q) + 1'b1 == len_q) begin
          state_d = rhpm_pkg::ST_FIN;
        end else begin
          state_d = rhpm_pkg::ST_V_RD;
        end
      end
      rhpm_pkg::ST_FIN: if (fin_go) state_d = rhpm_pkg::ST_IDLE;
      default: state_d = rhpm_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: unit command, ready and ring read address.
  always_comb begin
    in_if.ready = (state_q == rhpm_pkg::ST_IDLE);
    op_state    = 1'b1;
    mm_cmd.op   = rhpm_pkg::MM_MUL;
    mm_cmd.x    = 32'd0;
    mm_cmd.y    = {1'b0, b_q};
    mm_cmd.m    = m_eff;
    ring_raddr  = ptr_q;
    unique case (state_q)
      rhpm_pkg::ST_BRED: begin
        mm_cmd.op = rhpm_pkg::MM_REDUCE;
        mm_cmd.x  = {1'b0, base_q};
      end
      rhpm_pkg::ST_P_BP:  mm_cmd.x = {1'b0, bp_q};
      rhpm_pkg::ST_P_PH:  mm_cmd.x = {1'b0, ph_q};
      rhpm_pkg::ST_P_ADD, rhpm_pkg::ST_T_ADD: begin
        mm_cmd.op = rhpm_pkg::MM_REDUCE;
        mm_cmd.x  = {1'b0, acc_q} + {24'd0, byte_q};
      end
      rhpm_pkg::ST_T_HRED: begin
        mm_cmd.op = rhpm_pkg::MM_REDUCE;
        mm_cmd.x  = {1'b0, wh_q};
      end
      rhpm_pkg::ST_T_BPRED: begin
        mm_cmd.op = rhpm_pkg::MM_REDUCE;
        mm_cmd.x  = {1'b0, bp_q};
      end
      rhpm_pkg::ST_T_SUB: begin
        mm_cmd.x = {24'd0, ring_rd_q};
        mm_cmd.y = {1'b0, bpr_q};
      end
      rhpm_pkg::ST_T_MUL: mm_cmd.x = {1'b0, acc_q};
      rhpm_pkg::ST_T_PHRED: begin
        mm_cmd.op = rhpm_pkg::MM_REDUCE;
        mm_cmd.x  = {1'b0, ph_q};
      end
      rhpm_pkg::ST_V_RD, rhpm_pkg::ST_V_CMP: begin
        op_state   = 1'b0;
        ring_raddr = q_q;
      end
      default: op_state = 1'b0;
    endcase
    mm_cmd.start = op_state && !iss_q && !mm_rsp.busy;
  end

  // Memories with registered reads.
  always_ff @(posedge clk_i) begin
    if (state_q == rhpm_pkg::ST_IDLE && in_acc && !in_if.func && len_eff < MaxLen) begin
      pstore[len_eff[IdxW-1:0]] <= in_if.data_byte;
    end
    if (state_q == rhpm_pkg::ST_T_ADD && mm_rsp.done) begin
      ring[ptr_q] <= byte_q;
    end
    ring_rd_q <= ring[ring_raddr];
    pat_rd_q  <= pstore[k_q];
  end

  // Payload working registers.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      byte_q  <= in_if.data_byte;
      last_q  <= in_if.last_byte;
      txt_q   <= in_if.func;
      first_q <= (len_eff == '0);
    end
    if (mm_rsp.done) begin
      unique case (state_q)
        rhpm_pkg::ST_BRED:    b_q   <= mm_rsp.result[30:0];
        rhpm_pkg::ST_P_PH:    acc_q <= mm_rsp.result[30:0];
        rhpm_pkg::ST_T_HRED:  acc_q <= mm_rsp.result[30:0];
        rhpm_pkg::ST_T_BPRED: bpr_q <= mm_rsp.result[30:0];
        rhpm_pkg::ST_T_SUB:   sub_q <= mm_rsp.result[30:0];
        rhpm_pkg::ST_T_MUL:   acc_q <= mm_rsp.result[30:0];
        rhpm_pkg::ST_T_PHRED: phr_q <= mm_rsp.result[30:0];
        default: ;
      endcase
    end
    if (state_q == rhpm_pkg::ST_T_FIX) begin
      acc_q <= (fix_sum >= {1'b0, m_eff}) ? 31'(fix_sum - {1'b0, m_eff}) : fix_sum[30:0];
    end
    if (state_q == rhpm_pkg::ST_T_CHK) begin
      q_q <= ptr_q;
    end else if (state_q == rhpm_pkg::ST_V_CMP) begin
      q_q <= q_nx;
    end
  end

  // Control and search state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= rhpm_pkg::ST_IDLE;
      iss_q      <= 1'b0;
      len_q      <= '0;
      fill_q     <= '0;
      complete_q <= 1'b1;
      ph_q       <= '0;
      bp_q       <= 31'd1;
      wh_q       <= '0;
      pos_q      <= '0;
      ptr_q      <= '0;
      mc_q       <= '0;
      cc_q       <= '0;
      sc_q       <= '0;
      k_q        <= '0;
      ok_q       <= 1'b0;
      hit_q      <= 1'b0;
      ov_q       <= 1'b0;
    end else begin
      state_q <= state_d;
      if (mm_cmd.start) begin
        iss_q <= 1'b1;
      end else if (mm_rsp.done) begin
        iss_q <= 1'b0;
      end
      if (out_load) begin
        ov_q <= 1'b1;
      end else if (ov_q && out_if.ready) begin
        ov_q <= 1'b0;
      end
      unique case (state_q)
        rhpm_pkg::ST_IDLE: begin
          hit_q <= 1'b0;
          if (in_acc && !in_if.func) begin
            if (complete_q) begin
              ph_q   <= '0;
              bp_q   <= 31'd1;
              wh_q   <= '0;
              pos_q  <= '0;
              ptr_q  <= '0;
              fill_q <= '0;
              mc_q   <= '0;
            end
            len_q      <= (len_eff < MaxLen) ? len_eff + 1'b1 : len_eff;
            complete_q <= in_if.last_byte;
          end else if (in_acc) begin
            complete_q <= 1'b1;
            if (len_q == '0) begin
              if (in_if.last_byte) begin
                wh_q   <= '0;
                pos_q  <= '0;
                ptr_q  <= '0;
                fill_q <= '0;
                mc_q   <= '0;
              end else begin
                pos_q <= pos_q + 1'b1;
              end
            end
          end
        end
        rhpm_pkg::ST_P_BP:  if (mm_rsp.done) bp_q <= mm_rsp.result[30:0];
        rhpm_pkg::ST_P_ADD: if (mm_rsp.done) ph_q <= mm_rsp.result[30:0];
        rhpm_pkg::ST_T_ADD: begin
          if (mm_rsp.done) begin
            wh_q   <= mm_rsp.result[30:0];
            ptr_q  <= ptr_nx;
            fill_q <= fill_inc;
          end
        end
        rhpm_pkg::ST_T_CHK: begin
          k_q   <= '0;
          ok_q  <= 1'b1;
          hit_q <= (fill_q >= len_q && wh_q == phr_q);
        end
        rhpm_pkg::ST_V_CMP: begin
          if (ring_rd_q != pat_rd_q) begin
            ok_q <= 1'b0;
          end
          k_q <= k_q + 1'b1;
        end
        rhpm_pkg::ST_FIN: begin
          if (fin_go) begin
            cc_q <= cc_n;
            sc_q <= sc_n;
            if (last_q) begin
              wh_q   <= '0;
              pos_q  <= '0;
              ptr_q  <= '0;
              fill_q <= '0;
              mc_q   <= '0;
            end else begin
              mc_q  <= mc_n;
              pos_q <= pos_q + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Result word, loaded whenever a text byte finishes; it is offered only for a hit.
  always_ff @(posedge clk_i) begin
    if (state_q == rhpm_pkg::ST_FIN && fin_go) begin
      o_pos_q <= start_ext[31:0];
      o_ver_q <= ok_q;
      o_mc_q  <= mc_n;
      o_cc_q  <= cc_n;
      o_sc_q  <= sc_n;
    end
  end

  assign out_if.valid             = ov_q;
  assign out_if.match_position    = o_pos_q;
  assign out_if.verified          = o_ver_q;
  assign out_if.matches_in_search = o_mc_q;
  assign out_if.collision_total   = o_cc_q;
  assign out_if.search_total      = o_sc_q;

  // The unit is never started while it is still working.
  `RHPM_ASSERT(a_start_idle, mm_cmd.start |-> !mm_rsp.busy)
  // The window never holds more bytes than the pattern.
  `RHPM_ASSERT(a_fill_le_len, fill_q <= len_q)
  // The ring pointer stays inside the window.
  `RHPM_ASSERT(a_ptr_range, len_q == '0 || LenW'(ptr_q) < len_q)
  // A result word appears only after the final stage.
  `RHPM_ASSERT(a_out_from_fin,
      $rose(ov_q) |-> $past(state_q) == rhpm_pkg::ST_FIN)

endmodule

`default_nettype wire

// ----- sim/rolling_hash_pattern_matcher_tb.sv -----
`default_nettype none

module rolling_hash_pattern_matcher_tb;

  localparam int unsigned MAX_PAT = 64;
  localparam int unsigned FUNC_PATTERN = 0;
  localparam int unsigned FUNC_TEXT = 1;
  localparam longint unsigned CYCLE_LIMIT = 4_000_000;
  localparam int unsigned ITEM_TARGET = 1900;
  // Settling time after the last result.
  localparam int unsigned DRAIN_CYCLES = 400;

  typedef struct packed {
    logic       func;
    logic [7:0] data_byte;
    logic       last_byte;
  } byte_word_t;

  typedef struct packed {
    logic [31:0] match_position;
    logic        verified;
    logic [31:0] matches_in_search;
    logic [31:0] collision_total;
    logic [31:0] search_total;
  } hit_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  rhpm_in_if  in_if ();
  rhpm_out_if out_if ();
  rhpm_cfg_if cfg_if ();

  rolling_hash_pattern_matcher u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Matcher state mirrored by the predictor.
  longint unsigned mul_base, modulus;
  logic [7:0] pat_mem [MAX_PAT];
  logic [7:0] ring_mem [MAX_PAT];
  int unsigned pat_len, fill, rptr;
  bit pat_done;
  longint unsigned pat_hash, pow_base, win_hash, text_pos;
  logic [31:0] match_cnt, coll_cnt, search_cnt;

  byte_word_t byte_queue[$];
  hit_word_t hit_queue[$];
  bit failed = 1'b0;
  bit stim_done = 1'b0;
  longint unsigned cycles = 0;
  int unsigned in_gap = 0, out_gap = 0;
  int unsigned pushed = 0;

  function automatic logic [31:0] sat_up(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic void reset_search();
    win_hash = 0; text_pos = 0; rptr = 0; fill = 0; match_cnt = 0;
  endfunction

  function automatic void reset_matcher();
    mul_base = 257; modulus = 1000000007;
    pat_len = 0; pat_done = 1'b1; pat_hash = 0; pow_base = 1;
    coll_cnt = 0; search_cnt = 0;
    reset_search();
  endfunction

  // Advance the mirrored state by one accepted byte and queue any hit.
  function automatic void predict_hit(input byte_word_t w);
    longint unsigned m, b, h, sub;
    int unsigned p, q;
    bit ok, hit;
    hit_word_t r;
    m = (modulus == 0) ? 64'h8000_0000 : modulus;
    b = mul_base % m;
    hit = 1'b0;
    ok = 1'b1;
    if (w.func == FUNC_PATTERN[0]) begin
      if (pat_done) begin
        pat_len = 0; pat_hash = 0; pow_base = 1; pat_done = 1'b0;
        reset_search();
      end
      if (pat_len < MAX_PAT) begin
        if (pat_len > 0) pow_base = ((pow_base % m) * b) % m;
        pat_hash = ((pat_hash % m) * b + w.data_byte) % m;
        pat_mem[pat_len] = w.data_byte;
        pat_len++;
      end
      if (w.last_byte) pat_done = 1'b1;
      return;
    end
    pat_done = 1'b1;
    if (pat_len > 0) begin
      p = rptr % pat_len;
      h = win_hash % m;
      if (fill >= pat_len) begin
        sub = (longint'(ring_mem[p]) * (pow_base % m)) % m;
        h = (h + m - sub) % m;
      end
      h = (h * b + w.data_byte) % m;
      win_hash = h;
      ring_mem[p] = w.data_byte;
      rptr = (p + 1 == pat_len) ? 0 : p + 1;
      if (fill < pat_len) fill++;
      if (fill >= pat_len && win_hash == pat_hash % m) begin
        q = rptr;
        for (int k = 0; k < pat_len; k++) begin
          if (ring_mem[q] != pat_mem[k]) ok = 1'b0;
          q = (q + 1 == pat_len) ? 0 : q + 1;
        end
        if (ok) match_cnt = sat_up(match_cnt);
        else coll_cnt = sat_up(coll_cnt);
        r.match_position = 32'(text_pos - (pat_len - 1));
        r.verified = ok;
        hit = 1'b1;
      end
    end
    if (w.last_byte && pat_len > 0 && fill >= pat_len) search_cnt = sat_up(search_cnt);
    if (hit) begin
      r.matches_in_search = match_cnt;
      r.collision_total = coll_cnt;
      r.search_total = search_cnt;
      hit_queue.push_back(r);
    end
    if (w.last_byte) reset_search();
    else text_pos = 32'(text_pos + 1);
  endfunction

  // Byte driver: takes the next queued word after a random gap.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.func <= 1'b0;
      in_if.data_byte <= 8'd0;
      in_if.last_byte <= 1'b0;
      in_gap <= 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        predict_hit(byte_queue.pop_front());
        in_if.valid <= 1'b0;
        in_gap <= $urandom_range(0, 8);
      end else if (!in_if.valid) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
        end else if (byte_queue.size() > 0) begin
          in_if.valid <= 1'b1;
          in_if.func <= byte_queue[0].func;
          in_if.data_byte <= byte_queue[0].data_byte;
          in_if.last_byte <= byte_queue[0].last_byte;
        end
      end
    end
  end

  // Result monitor with a random ready stall per word.
  always @(posedge clk_i or negedge rst_ni) begin
    hit_word_t got, want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      out_gap <= 0;
    end else begin
      cycles <= cycles + 1;
      if (out_if.valid && out_if.ready) begin
        got.match_position = out_if.match_position;
        got.verified = out_if.verified;
        got.matches_in_search = out_if.matches_in_search;
        got.collision_total = out_if.collision_total;
        got.search_total = out_if.search_total;
        if (hit_queue.size() == 0) begin
          $display("%0t: result word expected none got %h", $time, got);
          failed = 1'b1;
        end else begin
          want = hit_queue.pop_front();
          if (got.match_position !== want.match_position)
            $display("%0t: match_position expected %0d got %0d", $time,
                     want.match_position, got.match_position);
          if (got.verified !== want.verified)
            $display("%0t: verified expected %0d got %0d", $time,
                     want.verified, got.verified);
          if (got.matches_in_search !== want.matches_in_search)
            $display("%0t: matches_in_search expected %0d got %0d", $time,
                     want.matches_in_search, got.matches_in_search);
          if (got.collision_total !== want.collision_total)
            $display("%0t: collision_total expected %0d got %0d", $time,
                     want.collision_total, got.collision_total);
          if (got.search_total !== want.search_total)
            $display("%0t: search_total expected %0d got %0d", $time,
                     want.search_total, got.search_total);
          if (got !== want) failed = 1'b1;
        end
        out_if.ready <= 1'b0;
        out_gap <= $urandom_range(0, 8);
      end else if (!out_if.ready) begin
        if (out_gap > 0) out_gap <= out_gap - 1;
        else out_if.ready <= 1'b1;
      end
      if (cycles > CYCLE_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic push_byte(input int unsigned f, input int unsigned d, input bit l);
    byte_word_t w;
    w.func = f[0];
    w.data_byte = d[7:0];
    w.last_byte = l;
    byte_queue.push_back(w);
    pushed++;
  endtask

  // Waits until every queued word is taken and every hit has come back.
  task automatic wait_idle();
    while (byte_queue.size() > 0 || in_if.valid || hit_queue.size() > 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [rhpm_pkg::CfgIdxW-1:0] idx,
                           input logic [31:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.wdata <= val;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    if (idx == rhpm_pkg::REG_HASH_BASE) mul_base = val[30:0];
    else modulus = val[30:0];
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // One search: a pattern, then text built from its bytes so hits occur.
  task automatic random_search(input int unsigned alpha);
    int unsigned len, tlen;
    logic [7:0] pat [MAX_PAT + 4];
    len = ($urandom_range(0, 19) == 0) ? $urandom_range(1, MAX_PAT + 4)
                                       : $urandom_range(1, 5);
    for (int i = 0; i < len; i++) begin
      pat[i] = (alpha == 0) ? 8'($urandom) : 8'($urandom_range(0, alpha));
      push_byte(FUNC_PATTERN, pat[i], i == len - 1 && $urandom_range(0, 7) != 0);
    end
    tlen = $urandom_range(0, 3) == 0 ? $urandom_range(1, 4) : $urandom_range(4, 24);
    for (int i = 0; i < tlen; i++) begin
      if ($urandom_range(0, 2) == 0 && len <= MAX_PAT)
        push_byte(FUNC_TEXT, pat[i % len], i == tlen - 1);
      else
        push_byte(FUNC_TEXT, (alpha == 0) ? $urandom : $urandom_range(0, alpha),
                  i == tlen - 1);
    end
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.func = 1'b0;
    in_if.data_byte = 8'd0;
    in_if.last_byte = 1'b0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = rhpm_pkg::REG_HASH_BASE;
    cfg_if.wdata = 32'd0;
    reset_matcher();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: text with no pattern, then extremes of the bytes.
    push_byte(FUNC_TEXT, 8'h00, 1'b0);
    push_byte(FUNC_TEXT, 8'hFF, 1'b1);
    push_byte(FUNC_PATTERN, 8'h00, 1'b0);
    push_byte(FUNC_PATTERN, 8'hFF, 1'b1);
    push_byte(FUNC_TEXT, 8'h00, 1'b0);
    push_byte(FUNC_TEXT, 8'hFF, 1'b0);
    push_byte(FUNC_TEXT, 8'h00, 1'b0);
    push_byte(FUNC_TEXT, 8'hFF, 1'b1);
    // Text closes an unfinished pattern; short text is not counted.
    push_byte(FUNC_PATTERN, 8'hA5, 1'b0);
    push_byte(FUNC_PATTERN, 8'h5A, 1'b0);
    push_byte(FUNC_TEXT, 8'hA5, 1'b1);
    // A new pattern discards a search in progress.
    push_byte(FUNC_TEXT, 8'hA5, 1'b0);
    push_byte(FUNC_PATTERN, 8'h42, 1'b1);
    push_byte(FUNC_TEXT, 8'h42, 1'b0);
    push_byte(FUNC_TEXT, 8'h42, 1'b1);
    wait_idle();

    // Tiny modulus forces collisions; zero modulus acts as two to the 31st.
    write_reg(rhpm_pkg::REG_HASH_MOD, 32'd2);
    write_reg(rhpm_pkg::REG_HASH_BASE, 32'd2);
    for (int s = 0; s < 6; s++) random_search(3);
    wait_idle();
    write_reg(rhpm_pkg::REG_HASH_MOD, 32'd0);
    write_reg(rhpm_pkg::REG_HASH_BASE, 32'h7FFF_FFFE);
    for (int s = 0; s < 6; s++) random_search(0);
    wait_idle();
    write_reg(rhpm_pkg::REG_HASH_MOD, 32'hFFFF_FFFF);
    write_reg(rhpm_pkg::REG_HASH_BASE, 32'hFFFF_FFFF);
    for (int s = 0; s < 6; s++) random_search(0);
    wait_idle();

    // Random phases over several register settings.
    while (pushed < ITEM_TARGET) begin
      case ($urandom_range(0, 3))
        0: begin
          write_reg(rhpm_pkg::REG_HASH_MOD, 32'd1000000007);
          write_reg(rhpm_pkg::REG_HASH_BASE, 32'd257);
        end
        1: begin
          write_reg(rhpm_pkg::REG_HASH_MOD, $urandom_range(2, 13));
          write_reg(rhpm_pkg::REG_HASH_BASE, $urandom);
        end
        2: begin
          write_reg(rhpm_pkg::REG_HASH_MOD, $urandom);
          write_reg(rhpm_pkg::REG_HASH_BASE, $urandom);
        end
        default: ;
      endcase
      for (int s = 0; s < 12; s++) begin
        if ($urandom_range(0, 9) == 0)
          push_byte($urandom_range(0, 1), $urandom, 1'($urandom_range(0, 1)));
        random_search($urandom_range(0, 1) ? 1 : 0);
      end
      wait_idle();
    end
    stim_done = 1'b1;

    if (!failed && hit_queue.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
